// ----- hw/rtl/swbg_pkg.sv -----
package swbg_pkg;

	// Sample width of the audio path (16 to 32)
	localparam int unsigned SAMPLE_BITS = 24;

	// Datapath widths, all derived from the sample width
	localparam int unsigned LW   = SAMPLE_BITS + 1;   // sample after polarity flip
	localparam int unsigned SUMW = SAMPLE_BITS + 2;   // l+r and l-r
	localparam int unsigned BW   = SUMW + 17;         // (l-r) * width
	localparam int unsigned WW   = SAMPLE_BITS + 20;  // mid +/- side, scale 2^15
	localparam int unsigned XW   = WW - 15;           // width stage result
	localparam int unsigned GW   = 18;                // balance gain, signed
	localparam int unsigned PW   = XW + GW;           // x * balance gain
	localparam int unsigned TW   = SAMPLE_BITS + 5;   // after balance
	localparam int unsigned QW   = TW + 17;           // t * linear gain
	localparam int unsigned RW   = QW - 12;           // before saturation

	localparam int unsigned CFG_DW = 16;
	localparam int unsigned CFG_IW = 3;

	typedef enum logic [CFG_IW-1:0] {
		REG_LINEAR_GAIN  = 3'd0,
		REG_BALANCE      = 3'd1,
		REG_WIDTH_FACTOR = 3'd2,
		REG_MONO_ENABLE  = 3'd3,
		REG_INVERT_LEFT  = 3'd4,
		REG_INVERT_RIGHT = 3'd5,
		REG_STEREO_MODE  = 3'd6
	} reg_idx_e;

	localparam logic [15:0] GAIN_RESET  = 16'd4096;
	localparam logic [15:0] WIDTH_RESET = 16'd16384;

	typedef struct packed {
		logic        [15:0] linear_gain;
		logic signed [15:0] balance;
		logic        [15:0] width_factor;
		logic               mono_enable;
		logic               invert_left;
		logic               invert_right;
		logic               stereo_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} out_t;

	// Clamp to the signed sample range
	function automatic logic signed [SAMPLE_BITS-1:0] sat_fn(input logic signed [RW-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[RW-1:SAMPLE_BITS-1];
		hi_zeros = ~|v[RW-1:SAMPLE_BITS-1];
		if (hi_ones || hi_zeros) begin
			sat_fn = v[SAMPLE_BITS-1:0];
		end else if (v[RW-1]) begin
			sat_fn = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			sat_fn = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	endfunction

endpackage

// ----- hw/rtl/stereo_width_balance_gain.sv -----
// Channel | Direction | Beat                              | Handshake
// in      | input     | in_data  (left_in, right_in)      | in_valid / in_ready
// out     | output    | out_data (left_out, right_out)    | out_valid / out_ready
// cfg     | input     | cfg_index, cfg_data (16 bits)     | cfg_valid / cfg_ready
//
// One beat per cycle sustained while out_ready stays high.
// The eight-stage datapath carries a valid bit per stage; empty stages fill while the
// output stalls, so in_ready drops only when every stage holds a beat.
// Reset (arst_n low) empties the pipeline and loads the register reset values.
// cfg_ready is always high; each register write takes effect at once.
module stereo_width_balance_gain (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  swbg_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output swbg_pkg::out_t                      out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swbg_pkg::CFG_IW-1:0]         cfg_index,
	input  logic [swbg_pkg::CFG_DW-1:0]         cfg_data
);

	swbg_pkg::cfg_t cfg_q;

	// Register file never backpressures
	assign cfg_ready = 1'b1;

	// Decode the write index; indexes past the list drop the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.linear_gain  <= swbg_pkg::GAIN_RESET;
			cfg_q.balance      <= '0;
			cfg_q.width_factor <= swbg_pkg::WIDTH_RESET;
			cfg_q.mono_enable  <= 1'b0;
			cfg_q.invert_left  <= 1'b0;
			cfg_q.invert_right <= 1'b0;
			cfg_q.stereo_mode  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				swbg_pkg::REG_LINEAR_GAIN:  cfg_q.linear_gain  <= cfg_data;
				swbg_pkg::REG_BALANCE:      cfg_q.balance      <= $signed(cfg_data);
				swbg_pkg::REG_WIDTH_FACTOR: cfg_q.width_factor <= cfg_data;
				swbg_pkg::REG_MONO_ENABLE:  cfg_q.mono_enable  <= cfg_data[0];
				swbg_pkg::REG_INVERT_LEFT:  cfg_q.invert_left  <= cfg_data[0];
				swbg_pkg::REG_INVERT_RIGHT: cfg_q.invert_right <= cfg_data[0];
				swbg_pkg::REG_STEREO_MODE:  cfg_q.stereo_mode  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Polarity, mid/side width, balance, gain and saturation
	swbg_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- hw/rtl/swbg_pipe.sv -----
module swbg_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  swbg_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  swbg_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output swbg_pkg::out_t  out_data
);

	localparam int unsigned SB = swbg_pkg::SAMPLE_BITS;
	localparam int unsigned LW = swbg_pkg::LW;
	localparam int unsigned SUMW = swbg_pkg::SUMW;
	localparam int unsigned BW = swbg_pkg::BW;
	localparam int unsigned WW = swbg_pkg::WW;
	localparam int unsigned XW = swbg_pkg::XW;
	localparam int unsigned GW = swbg_pkg::GW;
	localparam int unsigned PW = swbg_pkg::PW;
	localparam int unsigned TW = swbg_pkg::TW;
	localparam int unsigned QW = swbg_pkg::QW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	// A stage loads when it is empty or its successor moves
	assign en8 = !v_s8 || out_ready;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	// Stage 1: polarity
	logic signed [LW-1:0] lx_c, rx_c;
	logic signed [LW-1:0] l_s1, r_s1;
	logic signed [SB-1:0] rraw_s1;
	assign lx_c = {in_data.left_in[SB-1], in_data.left_in};
	assign rx_c = {in_data.right_in[SB-1], in_data.right_in};

	always_ff @(posedge clk) begin
		if (en1) begin
			l_s1    <= cfg.invert_left  ? -lx_c : lx_c;
			r_s1    <= cfg.invert_right ? -rx_c : rx_c;
			rraw_s1 <= in_data.right_in;
		end
	end

	// Stage 2: mid and side sums
	logic signed [SUMW-1:0] sum_s2, diff_s2;
	logic signed [LW-1:0]   l_s2;
	logic signed [SB-1:0]   rraw_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			sum_s2  <= SUMW'(l_s1) + SUMW'(r_s1);
			diff_s2 <= SUMW'(l_s1) - SUMW'(r_s1);
			l_s2    <= l_s1;
			rraw_s2 <= rraw_s1;
		end
	end

	// Stage 3: side times width; mono drops the side
	logic signed [BW-1:0]   b_c, b_s3;
	logic signed [SUMW-1:0] sum_s3;
	logic signed [LW-1:0]   l_s3;
	logic signed [SB-1:0]   rraw_s3;
	assign b_c = diff_s2 * $signed({1'b0, cfg.width_factor});

	always_ff @(posedge clk) begin
		if (en3) begin
			b_s3    <= cfg.mono_enable ? '0 : b_c;
			sum_s3  <= sum_s2;
			l_s3    <= l_s2;
			rraw_s3 <= rraw_s2;
		end
	end

	// Stage 4: combine and round away the 2^15 scale
	logic signed [WW-1:0] a_c, bx_c, wl_c, wr_c;
	logic signed [XW-1:0] xl_s4, xr_s4;
	logic signed [LW-1:0] l_s4;
	logic signed [SB-1:0] rraw_s4;
	assign a_c  = {{(WW-SUMW-14){sum_s3[SUMW-1]}}, sum_s3, 14'd0};
	assign bx_c = WW'(b_s3);
	assign wl_c = a_c + bx_c + WW'(1 << 14);
	assign wr_c = a_c - bx_c + WW'(1 << 14);

	always_ff @(posedge clk) begin
		if (en4) begin
			xl_s4   <= wl_c[WW-1:15];
			xr_s4   <= wr_c[WW-1:15];
			l_s4    <= l_s3;
			rraw_s4 <= rraw_s3;
		end
	end

	// Stage 5: balance taper
	logic signed [GW-1:0] bal_c, gl_c, gr_c;
	logic signed [PW-1:0] pl_s5, pr_s5;
	logic signed [LW-1:0] l_s5;
	logic signed [SB-1:0] rraw_s5;
	localparam logic signed [GW-1:0] BAL_UNITY = GW'(32768);
	assign bal_c = GW'(cfg.balance);
	assign gl_c  = (cfg.balance > 0) ? BAL_UNITY - bal_c : BAL_UNITY;
	assign gr_c  = (cfg.balance < 0) ? BAL_UNITY + bal_c : BAL_UNITY;

	always_ff @(posedge clk) begin
		if (en5) begin
			pl_s5   <= xl_s4 * gl_c;
			pr_s5   <= xr_s4 * gr_c;
			l_s5    <= l_s4;
			rraw_s5 <= rraw_s4;
		end
	end

	// Stage 6: round balance product; single-channel mode takes the polarity-adjusted left
	logic signed [PW-1:0] tl_c, tr_c;
	logic signed [TW-1:0] tl_s6, tr_s6;
	logic signed [SB-1:0] rraw_s6;
	assign tl_c = pl_s5 + PW'(1 << 14);
	assign tr_c = pr_s5 + PW'(1 << 14);

	always_ff @(posedge clk) begin
		if (en6) begin
			tl_s6   <= cfg.stereo_mode ? tl_c[TW+14:15] : TW'(l_s5);
			tr_s6   <= tr_c[TW+14:15];
			rraw_s6 <= rraw_s5;
		end
	end

	// Stage 7: output gain; the full product keeps its top bit only as sign
	logic signed [QW-1:0] ql_s7, qr_s7;
	logic signed [SB-1:0] rraw_s7;
	logic signed [17:0]   lg_c;
	logic signed [TW+17:0] ml_c, mr_c;
	assign lg_c = $signed({2'b00, cfg.linear_gain});
	assign ml_c = tl_s6 * lg_c;
	assign mr_c = tr_s6 * lg_c;

	always_ff @(posedge clk) begin
		if (en7) begin
			ql_s7   <= ml_c[QW-1:0];
			qr_s7   <= mr_c[QW-1:0];
			rraw_s7 <= rraw_s6;
		end
	end

	// Stage 8: round, saturate, hold for the consumer; single-channel mode passes the raw right
	logic signed [QW-1:0] rl_c, rr_c;
	assign rl_c = ql_s7 + QW'(1 << 11);
	assign rr_c = qr_s7 + QW'(1 << 11);

	always_ff @(posedge clk) begin
		if (en8) begin
			out_data.left_out  <= swbg_pkg::sat_fn(rl_c[QW-1:12]);
			out_data.right_out <= cfg.stereo_mode ? swbg_pkg::sat_fn(rr_c[QW-1:12]) : rraw_s7;
		end
	end

	assign out_valid = v_s8;

endmodule

// ----- bench/tb_top.sv -----
module tb_top;

	typedef logic signed [swbg_pkg::SAMPLE_BITS-1:0] sample_t;

	// Beats from input to output; also used as the settle time before register writes
	localparam int PIPE_DEPTH = 8;
	// Index past the last register: the block must ignore writes to it
	localparam logic [swbg_pkg::CFG_IW-1:0] REG_SPARE = 3'd7;
	localparam sample_t S_MAX = {1'b0, {(swbg_pkg::SAMPLE_BITS-1){1'b1}}};
	localparam sample_t S_MIN = {1'b1, {(swbg_pkg::SAMPLE_BITS-1){1'b0}}};

	// Predicts each output pair from the accepted input pair and the shadow registers,
	// and checks the output beats in order against those predictions.
	class stereo_checker;
		logic        [15:0] gain;
		logic signed [15:0] bal;
		logic        [15:0] width;
		bit                 mono, inv_l, inv_r, stereo;
		swbg_pkg::out_t     pending_pairs[$];
		int                 errors;

		function new();
			gain   = swbg_pkg::GAIN_RESET;
			bal    = '0;
			width  = swbg_pkg::WIDTH_RESET;
			mono   = 1'b0;
			inv_l  = 1'b0;
			inv_r  = 1'b0;
			stereo = 1'b1;
			errors = 0;
		endfunction

		function void set_reg(logic [swbg_pkg::CFG_IW-1:0] idx,
				logic [swbg_pkg::CFG_DW-1:0] val);
			case (idx)
				swbg_pkg::REG_LINEAR_GAIN:  gain   = val;
				swbg_pkg::REG_BALANCE:      bal    = val;
				swbg_pkg::REG_WIDTH_FACTOR: width  = val;
				swbg_pkg::REG_MONO_ENABLE:  mono   = val[0];
				swbg_pkg::REG_INVERT_LEFT:  inv_l  = val[0];
				swbg_pkg::REG_INVERT_RIGHT: inv_r  = val[0];
				swbg_pkg::REG_STEREO_MODE:  stereo = val[0];
				default: ;
			endcase
		endfunction

		// Divide by 2^sh, ties toward plus infinity
		function longint round_shift(longint v, int sh);
			return (v + (longint'(1) <<< (sh - 1))) >>> sh;
		endfunction

		function sample_t clamp(longint v);
			longint hi, lo;
			hi = (longint'(1) <<< (swbg_pkg::SAMPLE_BITS - 1)) - 1;
			lo = -(longint'(1) <<< (swbg_pkg::SAMPLE_BITS - 1));
			if (v > hi) v = hi;
			if (v < lo) v = lo;
			return v[swbg_pkg::SAMPLE_BITS-1:0];
		endfunction

		function sample_t scale_channel(longint wide, longint g);
			longint x, t;
			x = round_shift(wide, 15);
			t = round_shift(x * g, 15);
			return clamp(round_shift(t * longint'(gain), 12));
		endfunction

		function swbg_pkg::out_t mix_pair(swbg_pkg::in_t d);
			longint         l, r, mid, side, wl, wr, gl, gr;
			swbg_pkg::out_t res;
			l = longint'($signed(d.left_in));
			r = longint'($signed(d.right_in));
			if (inv_l) l = -l;
			if (!stereo) begin
				res.left_out  = clamp(round_shift(l * longint'(gain), 12));
				res.right_out = d.right_in;
				return res;
			end
			if (inv_r) r = -r;
			mid  = (l + r) * 16384;
			side = (l - r) * longint'(width);
			if (mono) begin
				wl = mid;
				wr = mid;
			end else begin
				wl = mid + side;
				wr = mid - side;
			end
			gl = (bal > 0) ? 32768 - longint'(bal) : 32768;
			gr = (bal < 0) ? 32768 + longint'(bal) : 32768;
			res.left_out  = scale_channel(wl, gl);
			res.right_out = scale_channel(wr, gr);
			return res;
		endfunction

		function void note_pair(swbg_pkg::in_t d);
			pending_pairs.push_back(mix_pair(d));
		endfunction

		function int pending();
			return pending_pairs.size();
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		task check_pair(swbg_pkg::out_t got);
			swbg_pkg::out_t want;
			if (pending_pairs.size() == 0) begin
				report("output beat with no input pending");
				return;
			end
			want = pending_pairs.pop_front();
			if (got.left_out !== want.left_out)
				report($sformatf("left_out %0d, want %0d",
					$signed(got.left_out), $signed(want.left_out)));
			if (got.right_out !== want.right_out)
				report($sformatf("right_out %0d, want %0d",
					$signed(got.right_out), $signed(want.right_out)));
		endtask

		task close_out();
			if (pending_pairs.size() != 0)
				report($sformatf("%0d output beats never arrived", pending_pairs.size()));
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	swbg_pkg::in_t                 in_data = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	swbg_pkg::out_t                out_data;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [swbg_pkg::CFG_IW-1:0]   cfg_index = '0;
	logic [swbg_pkg::CFG_DW-1:0]   cfg_data = '0;

	stereo_checker       checker_h;
	// Calm phases: neither side idles, so the pipeline runs back to back
	bit                  calm = 1'b0;
	// Idle cycles before the next input beat; after a beat, zero means in_valid was left high
	int                  in_gap = 0;

	stereo_width_balance_gain uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function int draw_gap();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// Rail and near-rail values, some small ones for rounding ties, otherwise uniform random
	function sample_t draw_sample();
		logic [31:0] raw;
		raw = $urandom();
		case ($urandom_range(0, 7))
			0: return S_MAX;
			1: return S_MIN;
			2: return sample_t'(S_MIN + 1);
			3: return sample_t'($signed($urandom_range(0, 600)) - 300);
			default: return raw[swbg_pkg::SAMPLE_BITS-1:0];
		endcase
	endfunction

	// Drive one input beat and hold it until accepted; called at a rising edge
	task send_pair(sample_t l, sample_t r);
		swbg_pkg::in_t beat;
		beat.left_in  = l;
		beat.right_in = r;
		repeat (in_gap) @(posedge clk);
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
		checker_h.note_pair(beat);
		// Drop valid only when a gap follows; otherwise keep streaming
		in_gap = draw_gap();
		if (in_gap != 0) in_valid <= 1'b0;
	endtask

	// Drain the pipeline so registers can be written with nothing in flight
	task quiesce();
		if (in_gap == 0) in_valid <= 1'b0;
		in_gap = 0;
		while (checker_h.pending() != 0) @(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task write_reg(logic [swbg_pkg::CFG_IW-1:0] idx, logic [swbg_pkg::CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		checker_h.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Write every register; the one-bit registers carry random junk above bit 0
	task program_regs(logic [15:0] gain, logic [15:0] bal, logic [15:0] width,
			bit mono, bit inv_l, bit inv_r, bit stereo);
		logic [31:0] junk;
		junk = $urandom();
		write_reg(swbg_pkg::REG_LINEAR_GAIN, gain);
		write_reg(swbg_pkg::REG_BALANCE, bal);
		write_reg(swbg_pkg::REG_WIDTH_FACTOR, width);
		write_reg(swbg_pkg::REG_MONO_ENABLE, {junk[14:0], mono});
		write_reg(swbg_pkg::REG_INVERT_LEFT, {junk[15:1], inv_l});
		write_reg(swbg_pkg::REG_INVERT_RIGHT, {junk[16:2], inv_r});
		write_reg(swbg_pkg::REG_STEREO_MODE, {junk[17:3], stereo});
		// Poke the unused index now and then; it must leave every register alone
		if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, junk[31:16]);
	endtask

	// Output side: stall a random number of cycles per beat, then take one beat
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			checker_h.check_pair(out_data);
		end
	end

	initial begin
		logic [15:0] gain, bal, width;
		logic [31:0] bits;
		checker_h = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: unity gain, unity width, centered balance
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MIN);
		send_pair(S_MAX, S_MIN);
		send_pair(S_MIN, S_MAX);
		send_pair('0, '0);
		send_pair(sample_t'(-1), sample_t'(1));

		// Top gain, widest side, right fully muted, both channels inverted;
		// negating the most negative sample must not wrap before the final clamp
		quiesce();
		program_regs(16'hFFFF, 16'h8000, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1);
		write_reg(REG_SPARE, 16'h1234);
		send_pair(S_MIN, S_MIN);
		send_pair(S_MIN, S_MAX);
		send_pair(S_MAX, sample_t'(-1));
		send_pair(sample_t'(12345), sample_t'(-54321));

		// Mono sum with left trimmed almost to nothing
		quiesce();
		program_regs(16'd4096, 16'sd32767, 16'd32768, 1'b1, 1'b0, 1'b1, 1'b1);
		send_pair(S_MAX, S_MIN);
		send_pair(S_MIN, S_MIN);
		send_pair(sample_t'(1), sample_t'(-1));

		// Single-channel path: right passes through untouched
		quiesce();
		program_regs(16'hFFFF, 16'sd0, 16'd16384, 1'b0, 1'b1, 1'b1, 1'b0);
		send_pair(S_MIN, S_MAX);
		send_pair(S_MAX, S_MIN);
		send_pair(sample_t'(-1), '0);
		send_pair('0, S_MIN);

		// Zero gain silences everything, zero width collapses to mid
		quiesce();
		program_regs(16'd0, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, sample_t'(5));

		// Random settings per phase, extremes favored; every fourth phase runs calm
		for (int phase = 0; phase < 14; phase++) begin
			quiesce();
			bits = $urandom();
			case ($urandom_range(0, 3))
				0: gain = 16'd0;
				1: gain = 16'hFFFF;
				2: gain = swbg_pkg::GAIN_RESET;
				default: gain = bits[15:0];
			endcase
			bits = $urandom();
			case ($urandom_range(0, 4))
				0: bal = 16'h8000;
				1: bal = 16'h8001;
				2: bal = 16'h7FFF;
				3: bal = 16'h0000;
				default: bal = bits[15:0];
			endcase
			bits = $urandom();
			case ($urandom_range(0, 4))
				0: width = 16'd0;
				1: width = swbg_pkg::WIDTH_RESET;
				2: width = 16'd32768;
				3: width = 16'hFFFF;
				default: width = bits[15:0];
			endcase
			bits = $urandom();
			program_regs(gain, bal, width, bits[0], bits[1], bits[2],
				bits[4:3] != 2'b00);
			calm = (phase % 4 == 3);
			repeat (100) send_pair(draw_sample(), draw_sample());
		end

		calm = 1'b0;
		quiesce();
		checker_h.close_out();
		if (checker_h.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/swbg_pkg.sv
hw/rtl/swbg_pipe.sv
hw/rtl/stereo_width_balance_gain.sv
bench/tb_top.sv
